/* rtl/assert_macros.svh */
// Assertion macros for the velocity field checker.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define CHK_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("check failed");
// valid held high with the payload unchanged while the receiver stalls
`define CHK_HOLD(lbl, clk, rst_n, vld, rdy, data) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) \
    vld && !rdy |=> vld && $stable(data)) \
    else $error("stalled transaction dropped or changed");
`endif

/* rtl/mlpsv_pkg.sv */
// Types, constants and arithmetic helpers for the MLP velocity field block.
// No dependencies.
package mlpsv_pkg;

  localparam int H      = 10;
  localparam int NIN    = 8;
  localparam int NOUT   = 3;
  localparam int WCOUNT = (NIN + 1) * H + (H + 1) * NOUT;
  localparam int WA_W   = $clog2(WCOUNT);
  localparam int IDX_W  = (H > 8) ? $clog2(H) : 3;
  localparam int HI_W   = (H > 1) ? $clog2(H) : 1;
  localparam int CNT_W  = $clog2(((H > NIN) ? H : NIN) + 1);

  localparam logic [16:0]        VL_RESET = 17'd19661;
  localparam logic signed [31:0] ONE_Q    = 32'sd65536;

  localparam logic [1:0] A_W   = 2'd0;
  localparam logic [1:0] A_CTX = 2'd1;
  localparam logic [1:0] A_SCL = 2'd2;

  localparam logic [1:0] B_ONE = 2'd0;
  localparam logic [1:0] B_CTX = 2'd1;
  localparam logic [1:0] B_HID = 2'd2;
  localparam logic [1:0] B_VL  = 2'd3;

  localparam logic [1:0] D_SQ  = 2'd0;
  localparam logic [1:0] D_HID = 2'd1;
  localparam logic [1:0] D_OUT = 2'd2;
  localparam logic [1:0] D_VEL = 2'd3;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EVAL = 1'b1;

  typedef struct packed {
    logic               cmd;
    logic [9:0]         weight_index;
    logic signed [31:0] weight_value;
    logic signed [31:0] body0_x;
    logic signed [31:0] body0_y;
    logic signed [31:0] body0_z;
    logic signed [31:0] body1_x;
    logic signed [31:0] body1_y;
    logic signed [31:0] body1_z;
    logic signed [31:0] body2_x;
    logic signed [31:0] body2_y;
    logic signed [31:0] body2_z;
  } in_t;

  typedef struct packed {
    logic [1:0]         body;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic               last;
  } out_t;

  typedef struct packed {
    logic             valid;
    logic             first;
    logic             last;
    logic [WA_W-1:0]  waddr;
    logic [1:0]       a_sel;
    logic [1:0]       b_sel;
    logic [IDX_W-1:0] idx;
    logic [1:0]       dest;
    logic [IDX_W-1:0] didx;
  } op_t;

  typedef struct packed {
    op_t        op;
    logic       ld_w;
    logic       ld_pos;
    logic       ofs;
    logic [1:0] body;
    logic       res_ld;
  } ctl_t;

  typedef struct packed {
    logic busy;
    logic res_free;
  } sts_t;

  typedef logic [15:0] sig_tab_t [256];

  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [64:0] rem;
    logic [63:0] q;
    rem = '0;
    q   = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], n[i]};
      if (rem >= {1'b0, d}) begin
        rem  = rem - {1'b0, d};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic sig_tab_t build_sig();
    logic [63:0] term;
    logic [63:0] q62;
    logic [63:0] q31;
    logic [63:0] p;
    logic [63:0] den;
    logic [63:0] r;
    logic [15:0] pos [256];
    sig_tab_t    t;
    term = 64'd1 << 62;
    q62  = term;
    for (int n = 1; n < 40; n++) begin
      if (term != 64'd0) begin
        term = udiv64(term, 64'(32 * n));
        if (n % 2 == 1) q62 = q62 - term;
        else q62 = q62 + term;
      end
    end
    q31    = (q62 + (64'd1 << 30)) >> 31;
    p      = q31;
    pos[0] = '0;
    for (int m = 1; m <= 255; m++) begin
      den    = (64'd1 << 31) + p;
      r      = udiv64((64'd1 << 47) + (den >> 1), den);
      pos[m] = r[15:0];
      p      = (p * q31 + (64'd1 << 30)) >> 31;
    end
    for (int k = 0; k < 256; k++) begin
      if (k >= 128) t[k] = pos[2 * k - 255];
      else t[k] = 16'(17'h10000 - {1'b0, pos[255 - 2 * k]});
    end
    return t;
  endfunction

  localparam sig_tab_t SIG_TAB = build_sig();

  function automatic logic [15:0] sig_lookup(input logic signed [31:0] x);
    logic signed [31:0] t;
    logic [7:0]         idx;
    t = x + 32'sd524288;
    if (x < -32'sd524288) idx = 8'd0;
    else if (x >= 32'sd524288) idx = 8'd255;
    else idx = t[19:12];
    return SIG_TAB[idx];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [55:0] v);
    if (v > 56'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -56'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage

/* rtl/mlpsv_ctrl.sv */
// Sequencer for the MLP velocity field: issues MAC operations per body and phase.
// Depends on mlpsv_pkg.
module mlpsv_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_cmd_i,
  output logic             in_ready_o,
  input  mlpsv_pkg::sts_t  sts_i,
  output mlpsv_pkg::ctl_t  ctl_o
);
  import mlpsv_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_OFS   = 3'd1;
  localparam logic [2:0] S_SQ    = 3'd2;
  localparam logic [2:0] S_HID   = 3'd3;
  localparam logic [2:0] S_OUTN  = 3'd4;
  localparam logic [2:0] S_SCL   = 3'd5;
  localparam logic [2:0] S_DRAIN = 3'd6;
  localparam logic [2:0] S_RES   = 3'd7;

  logic [2:0]       state_q, state_d, nxt_q, nxt_d;
  logic [1:0]       body_q, body_d;
  logic [CNT_W-1:0] j_q, j_d, h_q, h_d;
  logic [WA_W-1:0]  addr_q, addr_d;
  logic [CNT_W+1:0] sq_idx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      nxt_q   <= S_IDLE;
      body_q  <= '0;
      j_q     <= '0;
      h_q     <= '0;
      addr_q  <= '0;
    end else begin
      state_q <= state_d;
      nxt_q   <= nxt_d;
      body_q  <= body_d;
      j_q     <= j_d;
      h_q     <= h_d;
      addr_q  <= addr_d;
    end
  end

  assign sq_idx = (CNT_W + 2)'(h_q) * (CNT_W + 2)'(3) + (CNT_W + 2)'(j_q);

  always_comb begin
    state_d    = state_q;
    nxt_d      = nxt_q;
    body_d     = body_q;
    j_d        = j_q;
    h_d        = h_q;
    addr_d     = addr_q;
    in_ready_o = 1'b0;
    ctl_o      = '0;
    ctl_o.body = body_q;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_cmd_i == CMD_LOAD) begin
            ctl_o.ld_w = 1'b1;
          end else begin
            ctl_o.ld_pos = 1'b1;
            body_d       = '0;
            state_d      = S_OFS;
          end
        end
      end
      S_OFS: begin
        ctl_o.ofs = 1'b1;
        j_d       = '0;
        h_d       = '0;
        state_d   = S_SQ;
      end
      S_SQ: begin
        ctl_o.op.valid = 1'b1;
        ctl_o.op.first = (j_q == '0);
        ctl_o.op.last  = (j_q == CNT_W'(2));
        ctl_o.op.a_sel = A_CTX;
        ctl_o.op.b_sel = B_CTX;
        ctl_o.op.idx   = IDX_W'(sq_idx);
        ctl_o.op.dest  = D_SQ;
        ctl_o.op.didx  = IDX_W'(h_q);
        if (j_q == CNT_W'(2)) begin
          j_d = '0;
          h_d = h_q + 1'b1;
          if (h_q == CNT_W'(1)) begin
            h_d     = '0;
            addr_d  = '0;
            nxt_d   = S_HID;
            state_d = S_DRAIN;
          end
        end else begin
          j_d = j_q + 1'b1;
        end
      end
      S_HID: begin
        ctl_o.op.valid = 1'b1;
        ctl_o.op.first = (j_q == '0);
        ctl_o.op.last  = (j_q == CNT_W'(NIN));
        ctl_o.op.waddr = addr_q;
        ctl_o.op.a_sel = A_W;
        ctl_o.op.b_sel = (j_q == '0) ? B_ONE : B_CTX;
        ctl_o.op.idx   = IDX_W'(j_q - 1'b1);
        ctl_o.op.dest  = D_HID;
        ctl_o.op.didx  = IDX_W'(h_q);
        addr_d         = addr_q + 1'b1;
        if (j_q == CNT_W'(NIN)) begin
          j_d = '0;
          h_d = h_q + 1'b1;
          if (h_q == CNT_W'(H - 1)) begin
            h_d     = '0;
            nxt_d   = S_OUTN;
            state_d = S_DRAIN;
          end
        end else begin
          j_d = j_q + 1'b1;
        end
      end
      S_OUTN: begin
        ctl_o.op.valid = 1'b1;
        ctl_o.op.first = (j_q == '0);
        ctl_o.op.last  = (j_q == CNT_W'(H));
        ctl_o.op.waddr = addr_q;
        ctl_o.op.a_sel = A_W;
        ctl_o.op.b_sel = (j_q == '0) ? B_ONE : B_HID;
        ctl_o.op.idx   = IDX_W'(j_q - 1'b1);
        ctl_o.op.dest  = D_OUT;
        ctl_o.op.didx  = IDX_W'(h_q);
        addr_d         = addr_q + 1'b1;
        if (j_q == CNT_W'(H)) begin
          j_d = '0;
          h_d = h_q + 1'b1;
          if (h_q == CNT_W'(NOUT - 1)) begin
            h_d     = '0;
            nxt_d   = S_SCL;
            state_d = S_DRAIN;
          end
        end else begin
          j_d = j_q + 1'b1;
        end
      end
      S_SCL: begin
        ctl_o.op.valid = 1'b1;
        ctl_o.op.first = 1'b1;
        ctl_o.op.last  = 1'b1;
        ctl_o.op.a_sel = A_SCL;
        ctl_o.op.b_sel = B_VL;
        ctl_o.op.idx   = IDX_W'(h_q);
        ctl_o.op.dest  = D_VEL;
        ctl_o.op.didx  = IDX_W'(h_q);
        h_d            = h_q + 1'b1;
        if (h_q == CNT_W'(NOUT - 1)) begin
          h_d     = '0;
          nxt_d   = S_RES;
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!sts_i.busy) state_d = nxt_q;
      end
      S_RES: begin
        if (sts_i.res_free) begin
          ctl_o.res_ld = 1'b1;
          if (body_q == 2'd2) begin
            state_d = S_IDLE;
          end else begin
            body_d  = body_q + 1'b1;
            state_d = S_OFS;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

/* rtl/mlpsv_dp.sv */
// Datapath: weight store, operand registers, shared MAC pipeline, sigmoid, result register.
// Depends on mlpsv_pkg.
module mlpsv_dp (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mlpsv_pkg::ctl_t  ctl_i,
  output mlpsv_pkg::sts_t  sts_o,
  input  mlpsv_pkg::in_t   in_i,
  input  logic             cfg_valid_i,
  input  logic [16:0]      cfg_data_i,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output mlpsv_pkg::out_t  out_o
);
  import mlpsv_pkg::*;

  logic signed [31:0] wmem [WCOUNT];
  logic signed [31:0] w_q;
  logic signed [31:0] pos_q [3][3];
  logic signed [31:0] ctx_q [8];
  logic [15:0]        hid_q [H];
  logic [15:0]        s_q [NOUT];
  logic signed [31:0] vel_q [NOUT];
  logic [16:0]        vl_q;

  op_t                s1_q;
  logic signed [31:0] a, b;
  logic signed [63:0] p_q;
  logic               s2_v_q, s2_first_q, s2_last_q;
  logic [1:0]         s2_dest_q;
  logic [IDX_W-1:0]   s2_didx_q;
  logic signed [55:0] acc_q;
  logic               s3_v_q;
  logic [1:0]         s3_dest_q;
  logic [IDX_W-1:0]   s3_didx_q;
  logic signed [31:0] wb_sat;
  logic [15:0]        wb_sig;
  logic               out_v_q;
  out_t               out_q;
  logic [1:0]         o1, o2;

  function automatic logic signed [31:0] sub_sat(input logic signed [31:0] x,
                                                 input logic signed [31:0] y);
    logic signed [32:0] d;
    d = 33'(x) - 33'(y);
    if (d > 33'sd2147483647) return 32'sh7FFFFFFF;
    if (d < -33'sd2147483648) return 32'sh80000000;
    return d[31:0];
  endfunction

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld_w && (in_i.weight_index < 10'(WCOUNT))) begin
      wmem[in_i.weight_index[WA_W-1:0]] <= in_i.weight_value;
    end
    w_q <= wmem[ctl_i.op.waddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vl_q <= VL_RESET;
    else if (cfg_valid_i) vl_q <= cfg_data_i;
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld_pos) begin
      pos_q[0][0] <= in_i.body0_x;
      pos_q[0][1] <= in_i.body0_y;
      pos_q[0][2] <= in_i.body0_z;
      pos_q[1][0] <= in_i.body1_x;
      pos_q[1][1] <= in_i.body1_y;
      pos_q[1][2] <= in_i.body1_z;
      pos_q[2][0] <= in_i.body2_x;
      pos_q[2][1] <= in_i.body2_y;
      pos_q[2][2] <= in_i.body2_z;
    end
  end

  always_comb begin
    unique case (ctl_i.body)
      2'd0:    begin o1 = 2'd1; o2 = 2'd2; end
      2'd1:    begin o1 = 2'd2; o2 = 2'd0; end
      default: begin o1 = 2'd0; o2 = 2'd1; end
    endcase
  end

  always_comb begin
    unique case (s1_q.a_sel)
      A_W:     a = w_q;
      A_CTX:   a = ctx_q[s1_q.idx[2:0]];
      A_SCL:   a = {15'd0, s_q[s1_q.idx[1:0]], 1'b0} - ONE_Q;
      default: a = '0;
    endcase
    unique case (s1_q.b_sel)
      B_ONE:   b = ONE_Q;
      B_CTX:   b = ctx_q[s1_q.idx[2:0]];
      B_HID:   b = {16'd0, hid_q[s1_q.idx[HI_W-1:0]]};
      default: b = {15'd0, vl_q};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q   <= '0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else begin
      s1_q   <= ctl_i.op;
      s2_v_q <= s1_q.valid;
      s3_v_q <= s2_v_q && s2_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q        <= 64'(a) * 64'(b);
    s2_first_q <= s1_q.first;
    s2_last_q  <= s1_q.last;
    s2_dest_q  <= s1_q.dest;
    s2_didx_q  <= s1_q.didx;
    s3_dest_q  <= s2_dest_q;
    s3_didx_q  <= s2_didx_q;
    if (s2_v_q) begin
      acc_q <= (s2_first_q ? 56'sd0 : acc_q) + 56'(p_q >>> 16);
    end
  end

  assign wb_sat = sat32(acc_q);
  assign wb_sig = sig_lookup(wb_sat);

  always_ff @(posedge clk_i) begin
    if (ctl_i.ofs) begin
      for (int j = 0; j < 3; j++) begin
        ctx_q[j]     <= sub_sat(pos_q[ctl_i.body][j], pos_q[o1][j]);
        ctx_q[3 + j] <= sub_sat(pos_q[ctl_i.body][j], pos_q[o2][j]);
      end
    end
    if (s3_v_q) begin
      unique case (s3_dest_q)
        D_SQ:    ctx_q[{2'b11, s3_didx_q[0]}] <= wb_sat;
        D_HID:   hid_q[s3_didx_q[HI_W-1:0]] <= wb_sig;
        D_OUT:   s_q[s3_didx_q[1:0]] <= wb_sig;
        default: vel_q[s3_didx_q[1:0]] <= wb_sat;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_v_q <= 1'b0;
    else if (ctl_i.res_ld) out_v_q <= 1'b1;
    else if (out_ready_i) out_v_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.res_ld) begin
      out_q.body  <= ctl_i.body;
      out_q.vel_x <= vel_q[0];
      out_q.vel_y <= vel_q[1];
      out_q.vel_z <= vel_q[2];
      out_q.last  <= (ctl_i.body == 2'd2);
    end
  end

  assign sts_o.busy     = s1_q.valid | s2_v_q | s3_v_q;
  assign sts_o.res_free = !out_v_q || out_ready_i;
  assign out_valid_o    = out_v_q;
  assign out_o          = out_q;

endmodule

/* rtl/mlp_sphere_velocity_field.sv */
// Top level of the three-body MLP velocity field; joins sequencer and datapath.
// Depends on mlpsv_pkg, mlpsv_ctrl, mlpsv_dp.
//
//   channel | direction | handshake                 | payload
//   in      | input     | in_valid_i / in_ready_o   | in_i (in_t)
//   out     | output    | out_valid_o / out_ready_i | out_o (out_t), three per evaluation
//   cfg     | input     | cfg_valid_i / cfg_ready_o | cfg_data_i, velocity limit
//
// A load transaction is written to the weight store from the idle state. An evaluation
// runs through the single shared multiply-accumulate pipeline, one term per cycle while
// a layer is issued, with a drain between network layers. The result register holds a body's
// velocities while the next body is computed; a stalled output holds the sequencer
// only at the hand-off. Reset clears control state; the weight store is undefined.
module mlp_sphere_velocity_field (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  mlpsv_pkg::in_t   in_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output mlpsv_pkg::out_t  out_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [16:0]      cfg_data_i
);
  import mlpsv_pkg::*;

  ctl_t ctl;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  mlpsv_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_cmd_i   (in_i.cmd),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  mlpsv_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .sts_o       (sts),
    .in_i        (in_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_o       (out_o)
  );

endmodule

/* rtl/mlpsv_checker.sv */
// Port-level checks for the velocity field top level, bound to it.
// Depends on mlpsv_pkg and assert_macros.svh.
`include "assert_macros.svh"
module mlpsv_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_ready_o,
  input mlpsv_pkg::in_t  in_i,
  input logic            out_valid_o,
  input logic            out_ready_i,
  input mlpsv_pkg::out_t out_o,
  input logic            cfg_valid_i,
  input logic            cfg_ready_o
);
  import mlpsv_pkg::*;

  `CHK_HOLD(a_out_hold, clk_i, rst_ni, out_valid_o, out_ready_i, out_o)
  `CHK_ASSERT(a_last_body, clk_i, rst_ni, out_valid_o |-> (out_o.last == (out_o.body == 2'd2)))
  `CHK_ASSERT(a_body_range, clk_i, rst_ni, out_valid_o |-> (out_o.body != 2'd3))
  `CHK_ASSERT(a_eval_busy, clk_i, rst_ni, in_valid_i && in_ready_o && in_i.cmd |=> !in_ready_o)
  `CHK_ASSERT(a_cfg_ready, clk_i, rst_ni, cfg_valid_i |-> cfg_ready_o)

endmodule

bind mlp_sphere_velocity_field mlpsv_checker u_chk (.*);

/* bench/mlp_sphere_velocity_field_tb.sv */
// Testbench for mlp_sphere_velocity_field: weight loads, three-body evaluations and limit writes.
// Expected velocities come from a fixed-point network predictor kept in this file.
// Depends on mlpsv_pkg and the mlp_sphere_velocity_field RTL.
module mlp_sphere_velocity_field_tb;
  import mlpsv_pkg::*;

  localparam int NHID   = 10;
  localparam int NWORDS = 12 * NHID + 3;

  typedef struct {
    int   lim;
    in_t  item;
    bit   typed;
    out_t res [3];
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_t        out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [16:0] cfg_data = '0;

  mlp_sphere_velocity_field dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_i        (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_o       (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  logic signed [31:0] weights [NWORDS];
  logic [16:0]        vel_limit = 17'd19661;
  logic [15:0]        sig_lut [256];
  out_t               vel_expected [$];
  int                 mismatches = 0;
  int                 burst_left = 0;

  function automatic void build_sig_lut();
    longint unsigned term, q62, q31, p, den;
    longint unsigned pos [256];
    term = 64'd1 << 62;
    q62  = term;
    for (int n = 1; n < 40 && term != 0; n++) begin
      term = term / longint'(32 * n);
      if (n % 2 == 1) q62 = q62 - term;
      else q62 = q62 + term;
    end
    q31 = (q62 + (64'd1 << 30)) >> 31;
    p   = q31;
    for (int m = 1; m <= 255; m++) begin
      den    = (64'd1 << 31) + p;
      pos[m] = ((64'd1 << 47) + den / 2) / den;
      p      = (p * q31 + (64'd1 << 30)) >> 31;
    end
    for (int k = 0; k < 256; k++) begin
      if (k >= 128) sig_lut[k] = 16'(pos[2 * k - 255]);
      else sig_lut[k] = 16'(64'd65536 - pos[255 - 2 * k]);
    end
  endfunction

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return 32'(v);
  endfunction

  function automatic longint qmul(logic signed [31:0] a, logic signed [31:0] b);
    longint prod;
    prod = longint'(a) * longint'(b);
    return prod >>> 16;
  endfunction

  function automatic longint squash(logic signed [31:0] x);
    int idx;
    if (x < -32'sd524288) idx = 0;
    else if (x >= 32'sd524288) idx = 255;
    else idx = ((int'(x) + 524288) >> 12) & 255;
    return longint'(sig_lut[idx]);
  endfunction

  task automatic predict_velocities(input in_t it, output bit has_res, output out_t r [3]);
    logic signed [31:0] p [3][3];
    logic signed [31:0] feat [8];
    logic signed [31:0] hid [NHID];
    longint acc, v;
    int other, base;
    has_res = 1'b0;
    if (it.cmd == CMD_LOAD) begin
      if (it.weight_index < NWORDS) weights[it.weight_index] = it.weight_value;
      return;
    end
    has_res = 1'b1;
    p[0] = '{it.body0_x, it.body0_y, it.body0_z};
    p[1] = '{it.body1_x, it.body1_y, it.body1_z};
    p[2] = '{it.body2_x, it.body2_y, it.body2_z};
    for (int i = 0; i < 3; i++) begin
      for (int n = 1; n <= 2; n++) begin
        other = (i + n) % 3;
        for (int j = 0; j < 3; j++)
          feat[(n - 1) * 3 + j] = clamp32(longint'(p[i][j]) - longint'(p[other][j]));
      end
      for (int n = 0; n < 2; n++) begin
        acc = 0;
        for (int j = 0; j < 3; j++) acc += qmul(feat[n * 3 + j], feat[n * 3 + j]);
        feat[6 + n] = clamp32(acc);
      end
      for (int h = 0; h < NHID; h++) begin
        base = h * 9;
        acc  = longint'(weights[base]);
        for (int j = 0; j < 8; j++) acc += qmul(weights[base + 1 + j], feat[j]);
        hid[h] = 32'(squash(clamp32(acc)));
      end
      r[i].body = 2'(i);
      r[i].last = (i == 2);
      for (int o = 0; o < 3; o++) begin
        base = NHID * 9 + o * (NHID + 1);
        acc  = longint'(weights[base]);
        for (int j = 0; j < NHID; j++) acc += qmul(weights[base + 1 + j], hid[j]);
        v = (2 * squash(clamp32(acc)) - 65536) * longint'(vel_limit);
        v = v >>> 16;
        case (o)
          0: r[i].vel_x = clamp32(v);
          1: r[i].vel_y = clamp32(v);
          default: r[i].vel_z = clamp32(v);
        endcase
      end
    end
  endtask

  function automatic in_t load_item(int idx, logic signed [31:0] val);
    in_t it;
    it              = '0;
    it.cmd          = CMD_LOAD;
    it.weight_index = 10'(idx);
    it.weight_value = val;
    it.body0_x      = $urandom;
    it.body2_z      = $urandom;
    return it;
  endfunction

  function automatic in_t eval_item(logic signed [31:0] c [9]);
    in_t it;
    it              = '0;
    it.cmd          = CMD_EVAL;
    it.weight_index = 10'($urandom);
    it.weight_value = $urandom;
    {it.body0_x, it.body0_y, it.body0_z, it.body1_x, it.body1_y, it.body1_z,
     it.body2_x, it.body2_y, it.body2_z} = {c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7], c[8]};
    return it;
  endfunction

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0:       return $urandom;
      1:       return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
      2:       return $signed($urandom_range(0, 2097152)) - 32'sd1048576;
      default: return $signed($urandom_range(0, 262144)) - 32'sd131072;
    endcase
  endfunction

  function automatic logic signed [31:0] rand_weight();
    if ($urandom_range(0, 15) == 0) return $urandom;
    return $signed($urandom_range(0, 262144)) - 32'sd131072;
  endfunction

  function automatic in_t rand_eval();
    logic signed [31:0] c [9];
    foreach (c[k]) c[k] = rand_coord();
    return eval_item(c);
  endfunction

  task automatic send_item(input in_t it, input bit typed, input out_t given [3]);
    out_t pred [3];
    bit   has_res;
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    predict_velocities(it, has_res, pred);
    if (has_res) begin
      for (int i = 0; i < 3; i++)
        vel_expected.insert(vel_expected.size(), typed ? given[i] : pred[i]);
    end
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid   <= 1'b0;
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (vel_expected.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_limit(input logic [16:0] v);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    vel_limit = v;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  int   stall_mode = 0;
  int   stall_cnt  = 0;
  out_t want;

  always @(posedge clk) begin
    stall_cnt <= stall_cnt + 1;
    if (stall_cnt % 64 == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= ($urandom_range(0, 3) != 0);
      default: out_ready <= (stall_cnt % 8 < 3);
    endcase
    if (rst_n && out_valid && out_ready) begin
      if (vel_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: %p", out_data);
      end else begin
        want = vel_expected.pop_front();
        if (out_data.body !== want.body || out_data.vel_x !== want.vel_x ||
            out_data.vel_y !== want.vel_y || out_data.vel_z !== want.vel_z ||
            out_data.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %p, got %p", want, out_data);
        end
      end
    end
  end

  initial begin
    #4000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  stim_row_t          rows [$];
  stim_row_t          row;
  out_t               none [3];
  logic signed [31:0] c [9];
  logic [16:0]        phase_lim [4];

  initial begin
    build_sig_lut();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_limit(17'd0);
    for (int k = 0; k < NWORDS; k++) send_item(load_item(k, rand_weight()), 1'b0, none);

    // zero limit: every velocity is zero
    row.lim = -1;
    row.typed = 1'b1;
    for (int i = 0; i < 3; i++) row.res[i] = '{body: 2'(i), vel_x: 0, vel_y: 0, vel_z: 0, last: i == 2};
    c = '{default: 32'sh7FFFFFFF};
    row.item = eval_item(c);
    rows.insert(rows.size(), row);
    c = '{32'sh7FFFFFFF, 32'sh80000000, 0, 32'sh80000000, 32'sh7FFFFFFF, 0, 0, 0, 32'sh80000000};
    row.item = eval_item(c);
    rows.insert(rows.size(), row);

    row.typed = 1'b0;
    row.lim = 65536;
    c = '{default: 32'sh80000000};
    row.item = eval_item(c);
    rows.insert(rows.size(), row);
    row.lim = -1;
    c = '{default: 0};
    row.item = eval_item(c);
    rows.insert(rows.size(), row);
    c = '{32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000,
          32'sh80000000, 0, 0, 0};
    row.item = eval_item(c);
    rows.insert(rows.size(), row);
    c = '{65536, 0, 0, 0, 65536, 0, 0, 0, 65536};
    row.item = eval_item(c);
    rows.insert(rows.size(), row);
    row.item = load_item(NWORDS * 1 - 3 - NHID * 2 - 2, 32'sh7FFFFFFF);
    rows.insert(rows.size(), row);
    row.item = load_item(NWORDS - 1, 32'sh80000000);
    rows.insert(rows.size(), row);
    row.item = load_item(NWORDS, 32'sh7FFFFFFF);
    rows.insert(rows.size(), row);
    row.item = load_item(1023, 32'sh80000000);
    rows.insert(rows.size(), row);
    row.item = load_item(0, 32'sh7FFFFFFF);
    rows.insert(rows.size(), row);
    row.item = rand_eval();
    rows.insert(rows.size(), row);
    row.lim = 19661;
    row.item = rand_eval();
    rows.insert(rows.size(), row);
    row.lim = -1;
    for (int k = 0; k < 9; k++) begin
      row.item = load_item(k, rand_weight());
      rows.insert(rows.size(), row);
    end
    row.item = load_item(NWORDS - 1, rand_weight());
    rows.insert(rows.size(), row);
    row.item = rand_eval();
    rows.insert(rows.size(), row);

    foreach (rows[r]) begin
      if (rows[r].lim >= 0) write_limit(17'(rows[r].lim));
      send_item(rows[r].item, rows[r].typed, rows[r].res);
    end

    phase_lim = '{17'd19661, 17'd65536, 17'($urandom_range(1, 65535)), 17'd1};
    for (int ph = 0; ph < 4; ph++) begin
      write_limit(phase_lim[ph]);
      for (int n = 0; n < 31; n++) begin
        if ($urandom_range(0, 9) < 4) begin
          if ($urandom_range(0, 7) == 0)
            send_item(load_item($urandom_range(0, 1023), rand_weight()), 1'b0, none);
          else
            send_item(load_item($urandom_range(0, NWORDS - 1), rand_weight()), 1'b0, none);
        end else begin
          send_item(rand_eval(), 1'b0, none);
        end
      end
    end

    drain_results();
    repeat (100) @(posedge clk);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/mlpsv_pkg.sv
rtl/mlpsv_ctrl.sv
rtl/mlpsv_dp.sv
rtl/mlp_sphere_velocity_field.sv
rtl/mlpsv_checker.sv
bench/mlp_sphere_velocity_field_tb.sv
